>>> rtl/cdt_mmss_pkg.sv
// ----------------------------------------------------------------------------
// cdt_mmss_pkg
// Shared types, constants and helper functions for the MM:SS countdown timer.
// ----------------------------------------------------------------------------
package cdt_mmss_pkg;

  // One input sample: tick flags and raw active-low button levels.
  typedef struct packed {
    logic ms_tick;
    logic scan_tick;
    logic btn_load_n;
    logic btn_inc_n;
    logic btn_go_n;
    logic btn_clear_n;
  } sample_t;

  // One display result.
  typedef struct packed {
    logic [7:0]  segments;
    logic [3:0]  digit_enable;
    logic [1:0]  mode;
    logic [12:0] remaining;
    logic [12:0] preset;
  } result_t;

  // Timer modes, one-hot inside the block.
  typedef enum logic [3:0] {
    ST_SET     = 4'b0001,
    ST_RUNNING = 4'b0010,
    ST_PAUSED  = 4'b0100,
    ST_DONE    = 4'b1000
  } state_t;

  // Mode codes as they appear on the result.
  localparam logic [1:0] MODE_SET_CODE     = 2'd0;
  localparam logic [1:0] MODE_RUNNING_CODE = 2'd1;
  localparam logic [1:0] MODE_PAUSED_CODE  = 2'd2;
  localparam logic [1:0] MODE_DONE_CODE    = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
  localparam logic [1:0] CFG_SET_STEP         = 2'd1;
  localparam logic [1:0] CFG_SET_LIMIT        = 2'd2;

  // Button bit positions in the pressed vector.
  localparam int BTN_LOAD  = 0;
  localparam int BTN_INC   = 1;
  localparam int BTN_GO    = 2;
  localparam int BTN_CLEAR = 3;

  // Reset values.
  localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
  localparam logic [12:0] SET_STEP_RST         = 13'd10;
  localparam logic [12:0] SET_LIMIT_RST        = 13'd5999;
  localparam logic [12:0] SECONDS_RST          = 13'd60;

  // Reciprocal of 60: floor(r * 8739 / 2^19) equals r / 60 for any 13-bit r.
  localparam logic [13:0] MIN_RECIP = 14'd8739;
  localparam int          MIN_SHIFT = 19;

  // Reciprocal of 10: floor(v * 205 / 2^11) equals v / 10 for any 8-bit v.
  localparam logic [7:0] DEC_RECIP = 8'd205;
  localparam int         DEC_SHIFT = 11;

  localparam logic [7:0] DP_MASK = 8'h80;

  // Seven-segment pattern of one decimal digit, segment a in bit 0.
  function automatic logic [7:0] seven_seg(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

  // Encoded mode number of a one-hot state.
  function automatic logic [1:0] mode_code(input state_t st);
    logic [1:0] code;
    case (st)
      ST_SET:     code = MODE_SET_CODE;
      ST_RUNNING: code = MODE_RUNNING_CODE;
      ST_PAUSED:  code = MODE_PAUSED_CODE;
      ST_DONE:    code = MODE_DONE_CODE;
      default:    code = MODE_SET_CODE;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/countdown_timer_mmss_display.sv
// ----------------------------------------------------------------------------
// countdown_timer_mmss_display
// Countdown timer with button-driven mode machine and a multiplexed MM:SS
// seven-segment readout.
// ----------------------------------------------------------------------------
// A sample's result is registered through stages A, B, C and D in that order.
// Throughput: one sample per cycle while result_stall does not hold the pipeline; the
// mode machine updates in the accept cycle and the display path is a four-register pipeline behind it.
// Reset (rst, synchronous): timer returns to set mode with 60 s preset and
// remaining, configuration registers take their defaults, the pipeline empties.
module countdown_timer_mmss_display (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  cdt_mmss_pkg::sample_t sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output cdt_mmss_pkg::result_t result,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import cdt_mmss_pkg::*;

  // Snapshot of the timer taken after each sample.
  typedef struct packed {
    logic [1:0]  pos;
    logic [1:0]  mode;
    logic [12:0] remaining;
    logic [12:0] preset;
  } snap_t;

  // Configuration registers.
  logic [15:0] ticks_per_second;
  logic [12:0] set_step;
  logic [12:0] set_limit;

  // Timer state.
  state_t      mode_reg;
  logic [12:0] remaining_seconds;
  logic [12:0] preset_seconds;
  logic [15:0] ms_elapsed;
  logic [3:0]  previous_buttons;
  logic [1:0]  scan_position;

  // Next-state values.
  state_t      mode_next;
  logic [12:0] remaining_next;
  logic [12:0] preset_next;
  logic [15:0] ms_next;
  logic [1:0]  scan_next;
  logic [3:0]  buttons_now;
  logic [3:0]  pressed;
  logic [13:0] preset_sum;
  logic [16:0] ms_inc;
  logic [15:0] tick_limit;

  // Pipeline registers.
  logic        a_valid;
  snap_t       a_snap;
  logic        b_valid;
  snap_t       b_snap;
  logic [7:0]  b_min;
  logic        c_valid;
  snap_t       c_snap;
  logic [7:0]  c_val;

  // Pipeline control.
  logic        accept;
  logic        a_ready;
  logic        b_ready;
  logic        c_ready;
  logic        d_ready;

  // Display arithmetic.
  logic [26:0] min_prod;
  logic [12:0] min_x60;
  logic [12:0] sec_val;
  logic [15:0] dec_prod;
  logic [4:0]  dec_q;
  logic [4:0]  tens_digit;
  logic [7:0]  ones_val;
  logic [3:0]  digit;
  logic [7:0]  seg;

  // Handshake: each stage moves when the one after it has room.
  assign d_ready      = !result_valid || !result_stall;
  assign c_ready      = !c_valid || d_ready;
  assign b_ready      = !b_valid || c_ready;
  assign a_ready      = !a_valid || b_ready;
  assign sample_stall = !a_ready;
  assign accept       = sample_valid && a_ready;

  // Configuration writes; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TICKS_PER_SECOND_RST;
      set_step         <= SET_STEP_RST;
      set_limit        <= SET_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: ticks_per_second <= cfg_data;
        CFG_SET_STEP:         set_step         <= cfg_data[12:0];
        CFG_SET_LIMIT:        set_limit        <= cfg_data[12:0];
        default:              ;
      endcase
    end
  end

  // Button presses in priority order, then tick counting.
  always_comb begin
    buttons_now    = ~{sample.btn_clear_n, sample.btn_go_n, sample.btn_inc_n,
                       sample.btn_load_n};
    pressed        = buttons_now & ~previous_buttons;
    mode_next      = mode_reg;
    remaining_next = remaining_seconds;
    preset_next    = preset_seconds;
    ms_next        = ms_elapsed;
    preset_sum     = {1'b0, preset_seconds} + {1'b0, set_step};
    tick_limit     = (ticks_per_second == 16'd0) ? 16'd1 : ticks_per_second;
    ms_inc         = {1'b0, ms_elapsed} + 17'd1;

    if (pressed[BTN_LOAD] && mode_next == ST_SET) begin
      remaining_next = preset_next;
    end

    if (pressed[BTN_INC] && mode_next == ST_SET) begin
      preset_next    = (preset_sum > {1'b0, set_limit}) ? set_step : preset_sum[12:0];
      remaining_next = preset_next;
    end

    if (pressed[BTN_GO]) begin
      case (mode_next)
        ST_SET: begin
          mode_next      = ST_RUNNING;
          remaining_next = preset_next;
          ms_next        = 16'd0;
        end
        ST_RUNNING: begin
          mode_next = ST_PAUSED;
        end
        ST_PAUSED: begin
          mode_next = ST_RUNNING;
          ms_next   = 16'd0;
        end
        default: begin
          mode_next      = ST_SET;
          remaining_next = preset_next;
        end
      endcase
    end

    if (pressed[BTN_CLEAR]) begin
      mode_next      = ST_SET;
      remaining_next = preset_next;
    end

    // A full second lowers the time, or ends the run once it is at zero.
    if (mode_next == ST_RUNNING && sample.ms_tick) begin
      ms_inc = {1'b0, ms_next} + 17'd1;
      if (ms_inc >= {1'b0, tick_limit}) begin
        ms_next = 16'd0;
        if (remaining_next != 13'd0) begin
          remaining_next = remaining_next - 13'd1;
        end else begin
          mode_next = ST_DONE;
        end
      end else begin
        ms_next = ms_inc[15:0];
      end
    end

    scan_next = sample.scan_tick ? scan_position + 2'd1 : scan_position;
  end

  // Timer state registers, updated once per accepted sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg          <= ST_SET;
      remaining_seconds <= SECONDS_RST;
      preset_seconds    <= SECONDS_RST;
      ms_elapsed        <= 16'd0;
      previous_buttons  <= 4'd0;
      scan_position     <= 2'd0;
    end else if (accept) begin
      mode_reg          <= mode_next;
      remaining_seconds <= remaining_next;
      preset_seconds    <= preset_next;
      ms_elapsed        <= ms_next;
      previous_buttons  <= buttons_now;
      scan_position     <= scan_next;
    end
  end

  // Stage A: snapshot of the new state and the digit position before the scan step.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_snap.pos       <= scan_position;
      a_snap.mode      <= mode_code(mode_next);
      a_snap.remaining <= remaining_next;
      a_snap.preset    <= preset_next;
    end
  end

  // Stage B: whole minutes by multiplying with the reciprocal of 60.
  assign min_prod = 27'(a_snap.remaining) * 27'(MIN_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_snap <= a_snap;
      b_min  <= min_prod[MIN_SHIFT+7:MIN_SHIFT];
    end
  end

  // Stage C: seconds field, and the pair of digits that the position selects.
  assign min_x60 = ({5'd0, b_min} << 6) - ({5'd0, b_min} << 2);
  assign sec_val = b_snap.remaining - min_x60;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) begin
      c_snap <= b_snap;
      c_val  <= b_snap.pos[1] ? sec_val[7:0] : b_min;
    end
  end

  // Stage D: split into tens and ones, then look up the segment pattern.
  assign dec_prod   = 16'(c_val) * 16'(DEC_RECIP);
  assign dec_q      = dec_prod[DEC_SHIFT+4:DEC_SHIFT];
  assign tens_digit = (dec_q >= 5'd10) ? dec_q - 5'd10 : dec_q;
  assign ones_val   = c_val - ({3'd0, dec_q} << 3) - ({3'd0, dec_q} << 1);
  assign digit      = c_snap.pos[0] ? ones_val[3:0] : tens_digit[3:0];
  assign seg        = seven_seg(digit) | ((c_snap.pos == 2'd1) ? DP_MASK : 8'h00);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (d_ready) begin
      result_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_valid) begin
      result.segments     <= seg;
      result.digit_enable <= 4'b0001 << c_snap.pos;
      result.mode         <= c_snap.mode;
      result.remaining    <= c_snap.remaining;
      result.preset       <= c_snap.preset;
    end
  end

endmodule

>>> rtl/cdt_mmss_chk.sv
// ----------------------------------------------------------------------------
// cdt_mmss_chk
// Port-level checks for the countdown timer, bound to the top level.
// ----------------------------------------------------------------------------
module cdt_mmss_chk (
  input logic                  clk,
  input logic                  rst,
  input logic                  result_valid,
  input logic                  result_stall,
  input cdt_mmss_pkg::result_t result
);
  import cdt_mmss_pkg::*;

  // A stalled result beat stays put.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Exactly one digit is driven per result.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot(result.digit_enable))
    else $error("digit select not one-hot");

  // The decimal point belongs to the second digit only.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.segments[7] == result.digit_enable[1]))
    else $error("decimal point on wrong digit");

  // In set mode the remaining time always mirrors the preset.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.mode == MODE_SET_CODE) |-> result.remaining == result.preset)
    else $error("remaining differs from preset in set mode");

  // The countdown never climbs above the preset.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.remaining <= result.preset)
    else $error("remaining above preset");

endmodule

bind countdown_timer_mmss_display cdt_mmss_chk u_cdt_mmss_chk (.*);
